### sv/rational_number_alu_top_macros.svh
// assertion macros shared by the rational alu top level
`ifndef RATIONAL_NUMBER_ALU_TOP_MACROS_SVH
`define RATIONAL_NUMBER_ALU_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RNA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RNA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/rna_pkg.sv
// package: shared constants, op codes and controller/datapath types for the rational alu
`timescale 1ns / 1ps
`default_nettype none
package rna_pkg;

   localparam int unsigned OP_W  = 4;
   localparam int unsigned NUM_W = 33;
   localparam int unsigned DEN_W = 31;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV = 4'd3;
   localparam logic [OP_W-1:0] OP_EQ  = 4'd4;
   localparam logic [OP_W-1:0] OP_LT  = 4'd5;
   localparam logic [OP_W-1:0] OP_LE  = 4'd6;
   localparam logic [OP_W-1:0] OP_GT  = 4'd7;
   localparam logic [OP_W-1:0] OP_GE  = 4'd8;

   typedef enum logic [1:0] {
      MUL_FIRST,
      MUL_SECOND,
      MUL_THIRD
   } mul_step_type;

   typedef enum logic [1:0] {
      RED_ARITH,
      RED_LEFT,
      RED_RIGHT
   } red_sel_type;

   typedef struct packed {
      logic         load;
      logic         mul_en;
      mul_step_type mul_step;
      logic         red_start;
      red_sel_type  red_sel;
      logic         gcd_step;
      logic         gcd_latch;
      logic         div_start;
      logic         div_den;
      logic         div_step;
      logic         save_left;
      logic         publish;
   } cmd_type;

   typedef struct packed {
      logic op_arith;
      logic op_cmp;
      logic gcd_done;
      logic g_zero;
      logic div_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

### sv/rna_if.sv
// request and response channel interfaces of the rational alu
`timescale 1ns / 1ps
`default_nettype none
interface rna_req_if #(parameter int unsigned OPERAND_WIDTH = 16);
   logic                            valid;
   logic                            ready;
   logic [rna_pkg::OP_W-1:0]        op;
   logic signed [OPERAND_WIDTH-1:0] first_num;
   logic signed [OPERAND_WIDTH-1:0] first_den;
   logic signed [OPERAND_WIDTH-1:0] second_num;
   logic signed [OPERAND_WIDTH-1:0] second_den;

   modport source (output valid, op, first_num, first_den, second_num, second_den,
                   input ready);
   modport sink   (input valid, op, first_num, first_den, second_num, second_den,
                   output ready);
endinterface

interface rna_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [rna_pkg::NUM_W-1:0] res_num;
   logic [rna_pkg::DEN_W-1:0]        res_den;
   logic                             cmp_true;
   logic                             zero_den;

   modport source (output valid, res_num, res_den, cmp_true, zero_den, input ready);
   modport sink   (input valid, res_num, res_den, cmp_true, zero_den, output ready);
endinterface
`default_nettype wire

### sv/rna_ctrl.sv
// controller state machine sequencing products, gcd and divisions
`timescale 1ns / 1ps
`default_nettype none
module rna_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  rna_pkg::status_type status,
   output rna_pkg::cmd_type    cmd,
   output logic                req_ready
);
   import rna_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_RED_LOAD,
      S_GCD,
      S_DIVN_GO,
      S_DIVN,
      S_DIVD_GO,
      S_DIVD,
      S_POST,
      S_PUBLISH
   } state_type;

   state_type   state_ff, state_in;
   red_sel_type phase_ff, phase_in;

   // next state and command decode
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            if (!status.op_arith && !status.op_cmp) begin
               state_in = S_PUBLISH;
            end else begin
               cmd.mul_en   = 1'b1;
               cmd.mul_step = MUL_FIRST;
               state_in     = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MUL_SECOND;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MUL_THIRD;
            phase_in     = status.op_arith ? RED_ARITH : RED_LEFT;
            state_in     = S_RED_LOAD;
         end
         S_RED_LOAD: begin
            cmd.red_start = 1'b1;
            cmd.red_sel   = phase_ff;
            state_in      = S_GCD;
         end
         S_GCD: begin
            if (status.gcd_done) begin
               cmd.gcd_latch = 1'b1;
               state_in      = S_DIVN_GO;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIVN_GO: begin
            if (status.g_zero) begin
               state_in = S_POST;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_den   = 1'b0;
               state_in      = S_DIVN;
            end
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_DIVD_GO;
            end
         end
         S_DIVD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_den   = 1'b1;
            state_in      = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (phase_ff == RED_LEFT) begin
               cmd.save_left = 1'b1;
               phase_in      = RED_RIGHT;
               state_in      = S_RED_LOAD;
            end else begin
               state_in = S_PUBLISH;
            end
         end
         S_PUBLISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= RED_ARITH;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

### sv/rna_dp.sv
// datapath: operand registers, shared multiplier, binary gcd, restoring divider, output register
`timescale 1ns / 1ps
`default_nettype none
module rna_dp #(
   parameter int unsigned OPERAND_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rna_pkg::cmd_type                 cmd,
   output rna_pkg::status_type              status,
   input  logic [rna_pkg::OP_W-1:0]         req_op,
   input  logic signed [OPERAND_WIDTH-1:0]  req_first_num,
   input  logic signed [OPERAND_WIDTH-1:0]  req_first_den,
   input  logic signed [OPERAND_WIDTH-1:0]  req_second_num,
   input  logic signed [OPERAND_WIDTH-1:0]  req_second_den,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic signed [rna_pkg::NUM_W-1:0] rsp_res_num,
   output logic [rna_pkg::DEN_W-1:0]        rsp_res_den,
   output logic                             rsp_cmp_true,
   output logic                             rsp_zero_den
);
   import rna_pkg::*;

   localparam int unsigned PW = 2 * OPERAND_WIDTH;
   localparam int unsigned NW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
   localparam int unsigned KW = $clog2(NW);

   // operand registers
   logic [OP_W-1:0]                op_ff;
   logic signed [OPERAND_WIDTH-1:0] a_ff, b_ff, c_ff, d_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         a_ff  <= req_first_num;
         b_ff  <= req_first_den;
         c_ff  <= req_second_num;
         d_ff  <= req_second_den;
      end
   end

   // shared multiplier, one product a cycle
   logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
   logic signed [PW-1:0]            prod;
   logic signed [PW-1:0]            pr0_ff, pr1_ff, pr2_ff;

   always_comb begin
      unique case (cmd.mul_step)
         MUL_FIRST: begin
            mul_x = a_ff;
            mul_y = (op_ff == OP_MUL) ? c_ff : d_ff;
         end
         MUL_SECOND: begin
            mul_x = c_ff;
            mul_y = b_ff;
         end
         default: begin
            mul_x = b_ff;
            mul_y = d_ff;
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         unique case (cmd.mul_step)
            MUL_FIRST:  pr0_ff <= prod;
            MUL_SECOND: pr1_ff <= prod;
            default:    pr2_ff <= prod;
         endcase
      end
   end

   // raw numerator and denominator of the arithmetic result
   logic signed [NW-1:0] pr0_ext, pr1_ext, pr2_ext, n_arith, m_arith;

   assign pr0_ext = NW'(pr0_ff);
   assign pr1_ext = NW'(pr1_ff);
   assign pr2_ext = NW'(pr2_ff);

   always_comb begin
      priority case (op_ff)
         OP_ADD:  n_arith = pr0_ext + pr1_ext;
         OP_SUB:  n_arith = pr0_ext - pr1_ext;
         default: n_arith = pr0_ext;
      endcase
      m_arith = (op_ff == OP_DIV) ? pr1_ext : pr2_ext;
   end

   // fraction to reduce and its magnitudes
   logic signed [NW-1:0] src_n, src_d;
   logic [NW-1:0]        mag_n, mag_d;

   always_comb begin
      unique case (cmd.red_sel)
         RED_ARITH: begin
            src_n = n_arith;
            src_d = m_arith;
         end
         RED_LEFT: begin
            src_n = NW'(a_ff);
            src_d = NW'(b_ff);
         end
         default: begin
            src_n = NW'(c_ff);
            src_d = NW'(d_ff);
         end
      endcase
      mag_n = src_n[NW-1] ? NW'(-src_n) : NW'(src_n);
      mag_d = src_d[NW-1] ? NW'(-src_d) : NW'(src_d);
   end

   // binary gcd, one shift or subtract a cycle
   logic [NW-1:0] u_ff, v_ff, u_in, v_in, g_ff;
   logic [KW-1:0] k_ff, k_in;
   logic          neg_ff;
   logic          gcd_done;

   assign gcd_done = (u_ff == '0) || (v_ff == '0);

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      priority if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = k_ff + KW'(1);
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = u_ff - v_ff;
      end else begin
         v_in = v_ff - u_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.red_start) begin
         u_ff   <= mag_n;
         v_ff   <= mag_d;
         k_ff   <= '0;
         neg_ff <= src_n[NW-1] ^ src_d[NW-1];
      end else if (cmd.gcd_step) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
      if (cmd.gcd_latch) begin
         g_ff <= (u_ff | v_ff) << k_ff;
      end
   end

   // restoring divider, one quotient bit a cycle
   logic [NW-1:0] rem_ff, quo_ff, qn_ff, qd_ff;
   logic [NW:0]   div_sh, div_diff;
   logic [KW-1:0] cnt_ff;
   logic          div_tgt_ff;
   logic          div_last;
   logic          div_ge;
   logic [NW-1:0] rem_in, quo_in;

   assign div_sh   = {rem_ff, quo_ff[NW-1]};
   assign div_diff = div_sh - {1'b0, g_ff};
   assign div_ge   = (div_sh >= {1'b0, g_ff});
   assign rem_in   = div_ge ? div_diff[NW-1:0] : div_sh[NW-1:0];
   assign quo_in   = {quo_ff[NW-2:0], div_ge};
   assign div_last = (cnt_ff == KW'(NW - 1));

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff     <= '0;
         quo_ff     <= cmd.div_den ? qd_ff : qn_ff;
         cnt_ff     <= '0;
         div_tgt_ff <= cmd.div_den;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + KW'(1);
      end
   end

   // reduced magnitudes; a zero gcd leaves both at zero
   always_ff @(posedge clock) begin
      if (cmd.red_start) begin
         qn_ff <= mag_n;
         qd_ff <= mag_d;
      end else if (cmd.div_step && div_last) begin
         if (div_tgt_ff) begin
            qd_ff <= quo_in;
         end else begin
            qn_ff <= quo_in;
         end
      end
   end

   // left operand kept for the equality test
   logic [NW-1:0] lqn_ff, lqd_ff;
   logic          lneg_ff;

   always_ff @(posedge clock) begin
      if (cmd.save_left) begin
         lqn_ff  <= qn_ff;
         lqd_ff  <= qd_ff;
         lneg_ff <= neg_ff;
      end
   end

   // result formation
   logic [NW-1:0] num_full;
   logic          eq, lt, cmp;
   logic          op_arith, op_cmp;

   assign op_arith = (op_ff <= OP_DIV);
   assign op_cmp   = (op_ff >= OP_EQ) && (op_ff <= OP_GE);
   assign num_full = neg_ff ? NW'(-qn_ff) : qn_ff;
   assign eq       = (lqn_ff == qn_ff) && (lqd_ff == qd_ff)
                     && ((lneg_ff == neg_ff) || (qn_ff == '0));
   assign lt       = (pr0_ff < pr1_ff);

   always_comb begin
      priority case (op_ff)
         OP_EQ:   cmp = eq;
         OP_LT:   cmp = lt;
         OP_LE:   cmp = lt || eq;
         OP_GT:   cmp = !(lt || eq);
         default: cmp = !lt;
      endcase
   end

   // output register
   logic                     rsp_valid_ff;
   logic signed [NUM_W-1:0]  res_num_ff;
   logic [DEN_W-1:0]         res_den_ff;
   logic                     cmp_true_ff, zero_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         if (op_arith) begin
            res_num_ff  <= NUM_W'($signed(num_full));
            res_den_ff  <= DEN_W'(qd_ff);
            cmp_true_ff <= 1'b0;
            zero_den_ff <= (qd_ff == '0);
         end else begin
            res_num_ff  <= '0;
            res_den_ff  <= '0;
            cmp_true_ff <= op_cmp && cmp;
            zero_den_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = res_num_ff;
   assign rsp_res_den  = res_den_ff;
   assign rsp_cmp_true = cmp_true_ff;
   assign rsp_zero_den = zero_den_ff;

   // status to the controller
   assign status.op_arith = op_arith;
   assign status.op_cmp   = op_cmp;
   assign status.gcd_done = gcd_done;
   assign status.g_zero   = (g_ff == '0);
   assign status.div_last = div_last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

### sv/rational_number_alu_top.sv
// top level of the rational alu: controller, datapath and assertions
//
// one request carries an op code and two signed fractions; each request
// gives exactly one response on the rsp channel (valid/ready).
// arithmetic ops form cross products on one shared multiplier and
// reduce by a binary gcd of s steps (one shift or subtract a
// cycle, s at most two per bit of the two magnitudes, so below 4*NW,
// NW = 2*OPERAND_WIDTH+1 capped at 64) and divide numerator and
// denominator by the gcd on a restoring divider.
// 0/0 skips the division; compare ops reduce both operands;
// unused op codes skip the products and go straight to the response.
// requests are taken one at a time: ready is high only while idle.
// the response sits in an output register; the next request is accepted
// while it waits, and a stalled receiver only holds the block at the end
// of the following request.
// reset is synchronous and clears the controller and the response valid.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_number_alu_top_macros.svh"
module rational_number_alu_top #(
   parameter int unsigned OPERAND_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   rna_req_if.sink      req_chan,
   rna_rsp_if.source    rsp_chan
);
   import rna_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_fire;
   logic       req_ready;
   logic       flags_clash;
   logic       den_clash;

   assign req_fire       = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   // controller
   rna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   // datapath
   rna_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_chan.op),
      .req_first_num  (req_chan.first_num),
      .req_first_den  (req_chan.first_den),
      .req_second_num (req_chan.second_num),
      .req_second_den (req_chan.second_den),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_res_num    (rsp_chan.res_num),
      .rsp_res_den    (rsp_chan.res_den),
      .rsp_cmp_true   (rsp_chan.cmp_true),
      .rsp_zero_den   (rsp_chan.zero_den)
   );

   // flag combinations that never occur on a response
   assign flags_clash = rsp_chan.zero_den && rsp_chan.cmp_true;
   assign den_clash   = rsp_chan.zero_den && (rsp_chan.res_den != '0);

   // assertions
   `RNA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_ready, "ready after request")
   `RNA_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_chan.valid, "publish lost")
   `RNA_ASSERT_SAME(a_flags_apart, clock, reset, rsp_chan.valid, !flags_clash, "both flags set")
   `RNA_ASSERT_SAME(a_zero_den_value, clock, reset, rsp_chan.valid, !den_clash, "zero_den with den")

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// testbench for the rational alu: random and directed requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import rna_pkg::*;

   localparam int unsigned OW = 16;
   localparam int unsigned WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic signed [OW-1:0]   a;
      logic signed [OW-1:0]   b;
      logic signed [OW-1:0]   c;
      logic signed [OW-1:0]   d;
   } alu_request_t;

   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
      logic                    cmp;
      logic                    zd;
   } alu_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rna_req_if #(.OPERAND_WIDTH(OW)) req_chan ();
   rna_rsp_if rsp_chan ();

   rational_number_alu_top #(.OPERAND_WIDTH(OW)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   alu_request_t pending_requests[$];
   alu_result_t  expected_results[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  quiet_phase = 1'b0;
   bit  hold_sender = 1'b0;

   // reduce n/m by the gcd of the magnitudes, sign onto the numerator
   function automatic void reduce_fraction(input longint n, input longint m,
                                           output longint rn, output longint rd);
      longint unsigned mn, md, x, y, t;
      bit neg;
      mn = (n < 0) ? -n : n;
      md = (m < 0) ? -m : m;
      neg = (n < 0) != (m < 0);
      x = mn;
      y = md;
      while (y != 0) begin
         t = y;
         y = x % y;
         x = t;
      end
      if (x != 0) begin
         mn = mn / x;
         md = md / x;
      end
      rn = neg ? -longint'(mn) : longint'(mn);
      rd = longint'(md);
   endfunction

   // expected response for one request
   function automatic alu_result_t predict_result(input alu_request_t r);
      alu_result_t res;
      longint a, b, c, d, ad, cb, n, m, rn, rd, ln, ld, qn, qd;
      bit lt, eq;
      a = r.a; b = r.b; c = r.c; d = r.d;
      ad = a * d;
      cb = c * b;
      n = 0;
      m = 0;
      res = '0;
      if (r.op <= OP_DIV) begin
         case (r.op)
            OP_ADD: begin n = ad + cb; m = b * d; end
            OP_SUB: begin n = ad - cb; m = b * d; end
            OP_MUL: begin n = a * c; m = b * d; end
            default: begin n = ad; m = b * c; end
         endcase
         reduce_fraction(n, m, rn, rd);
         res.num = rn[NUM_W-1:0];
         res.den = rd[DEN_W-1:0];
         res.zd  = (rd == 0);
      end else if (r.op <= OP_GE) begin
         reduce_fraction(a, b, ln, ld);
         reduce_fraction(c, d, qn, qd);
         eq = (ln == qn) && (ld == qd);
         lt = ad < cb;
         case (r.op)
            OP_EQ: res.cmp = eq;
            OP_LT: res.cmp = lt;
            OP_LE: res.cmp = lt || eq;
            OP_GT: res.cmp = !(lt || eq);
            default: res.cmp = !lt;
         endcase
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [OW-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return '0;
         3: return 16'($signed($urandom_range(0, 6)) - 3);
         4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic alu_request_t random_request();
      alu_request_t r;
      r.op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(9, 15))
                                         : OP_W'($urandom_range(0, 8));
      r.a = pick_operand();
      r.b = pick_operand();
      r.c = pick_operand();
      r.d = pick_operand();
      // equal fractions so equality and ordering ties are hit
      if ($urandom_range(0, 7) == 0) begin
         r.c = r.a * 2;
         r.d = r.b * 2;
      end
      return r;
   endfunction

   function automatic alu_request_t make_request(input logic [OP_W-1:0] op,
      input logic [OW-1:0] a, input logic [OW-1:0] b,
      input logic [OW-1:0] c, input logic [OW-1:0] d);
      alu_request_t r;
      r.op = op; r.a = a; r.b = b; r.c = c; r.d = d;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.op <= '0;
         req_chan.first_num <= '0;
         req_chan.first_den <= '0;
         req_chan.second_num <= '0;
         req_chan.second_den <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid && req_chan.ready)
            expected_results.push_back(predict_result({req_chan.op, req_chan.first_num,
               req_chan.first_den, req_chan.second_num, req_chan.second_den}));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_requests.size() > 0 && !hold_sender) begin
            alu_request_t r;
            r = pending_requests.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.op <= r.op;
            req_chan.first_num <= r.a;
            req_chan.first_den <= r.b;
            req_chan.second_num <= r.c;
            req_chan.second_den <= r.d;
            if (!quiet_phase && $urandom_range(0, 3) == 0)
               send_gap <= $urandom_range(1, 4);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               alu_result_t e;
               e = expected_results.pop_front();
               if (rsp_chan.res_num !== e.num)
                  report_mismatch("res_num", rsp_chan.res_num, e.num);
               if (rsp_chan.res_den !== e.den)
                  report_mismatch("res_den", rsp_chan.res_den, e.den);
               if (rsp_chan.cmp_true !== e.cmp)
                  report_mismatch("cmp_true", rsp_chan.cmp_true, e.cmp);
               if (rsp_chan.zero_den !== e.zd)
                  report_mismatch("zero_den", rsp_chan.zero_den, e.zd);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: every op, field extremes, zero denominators and 0/0
      for (k = 0; k <= 8; k++)
         pending_requests.push_back(make_request(OP_W'(k), 16'h8000, 16'h7fff,
                                                 16'h8000, 16'h8000));
      pending_requests.push_back(make_request(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
      pending_requests.push_back(make_request(OP_SUB, 16'h0003, 16'h0000, 16'h0005, 16'h0007));
      pending_requests.push_back(make_request(OP_MUL, 16'h0000, 16'h0000, 16'h0004, 16'h0002));
      pending_requests.push_back(make_request(OP_DIV, 16'h0003, 16'h0004, 16'h0000, 16'h0005));
      pending_requests.push_back(make_request(OP_DIV, 16'hfffa, 16'h0004, 16'h0003, 16'hfff8));
      pending_requests.push_back(make_request(OP_EQ, 16'h0001, 16'h0002, 16'hfffe, 16'hfffc));
      pending_requests.push_back(make_request(OP_LT, 16'h0001, 16'hfffe, 16'h0001, 16'h0003));
      pending_requests.push_back(make_request(OP_GE, 16'h0002, 16'h0004, 16'h0001, 16'h0002));
      pending_requests.push_back(make_request(OP_W'(9), 16'h1234, 16'h0001, 16'h0001, 16'h0001));
      pending_requests.push_back(make_request(OP_W'(15), 16'hffff, 16'hffff, 16'hffff, 16'hffff));
      pending_requests.push_back(make_request(OP_ADD, 16'hffff, 16'hffff, 16'h5555, 16'haaaa));
      // let the sender wait until everything is back
      while (pending_requests.size() > 0 || req_chan.valid) @(posedge clock);
      hold_sender = 1'b1;
      while (expected_results.size() > 0) @(posedge clock);
      hold_sender = 1'b0;
      for (k = 0; k < 1930; k++) begin
         pending_requests.push_back(random_request());
         if (k == 1500) begin
            while (pending_requests.size() > 0) @(posedge clock);
            quiet_phase = 1'b1;
         end
      end
      while (pending_requests.size() > 0 || req_chan.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

### rational_number_alu_top.f
+incdir+sv
sv/rna_pkg.sv
sv/rna_if.sv
sv/rna_ctrl.sv
sv/rna_dp.sv
sv/rational_number_alu_top.sv
tb/sv/tb_top.sv
